// ===== hw/rtl/two_hand_tracker_gestures_defines.svh =====
// Assertion macros shared by the two-hand tracker RTL.
// Expects signals clk and arst_n in the scope that uses them.
`ifndef TWO_HAND_TRACKER_GESTURES_DEFINES_SVH
`define TWO_HAND_TRACKER_GESTURES_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define THT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define THT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define THT_ASSERT_IMP(lbl, ante, cons, msg)
`define THT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/tht_pkg.sv =====
// Shared types and constants of the two-hand tracker.
// No dependencies; every other RTL file except the assertion macro header uses this package.
package tht_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int TIMER_BITS_DEF = 16;

	localparam int TIMEOUT_W  = 16;
	localparam int FALL_W     = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [TIMEOUT_W-1:0] ABSENCE_TIMEOUT_RST = 16'd500;
	localparam logic [FALL_W-1:0]    FALL_THRESHOLD_RST  = 12'd0;

	// Field slots of a packed box vector.
	localparam int BOX_X      = 0;
	localparam int BOX_Y      = 1;
	localparam int BOX_W      = 2;
	localparam int BOX_H      = 3;
	localparam int BOX_FIELDS = 4;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_BOX   = 2'd1,
		ACT_EMPTY = 2'd2,
		ACT_RSVD  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ABSENCE_TIMEOUT = 1'b0,
		CFG_FALL_THRESHOLD  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic left;
		logic right;
	} presence_t;

endpackage

// ===== hw/rtl/tht_ifs.sv =====
// Channel interfaces of the two-hand tracker: detections, results, config.
// Depends on tht_pkg.
interface tht_det_if #(parameter int COORD_BITS = tht_pkg::COORD_BITS_DEF);
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [COORD_BITS-1:0] box_x;
	logic [COORD_BITS-1:0] box_y;
	logic [COORD_BITS-1:0] box_width;
	logic [COORD_BITS-1:0] box_height;
	logic                  last_in_frame;

	modport source(output valid, action, box_x, box_y, box_width, box_height,
		last_in_frame, input ready);
	modport sink(input valid, action, box_x, box_y, box_width, box_height,
		last_in_frame, output ready);
endinterface

interface tht_out_if #(parameter int COORD_BITS = tht_pkg::COORD_BITS_DEF);
	logic                  valid;
	logic                  ready;
	logic                  left_present;
	logic                  right_present;
	logic                  rotate_hit;
	logic                  strafe_right_hit;
	logic                  strafe_left_hit;
	logic                  fast_fall_hit;
	logic [COORD_BITS-1:0] left_pos_x;
	logic [COORD_BITS-1:0] right_pos_x;

	modport source(output valid, left_present, right_present, rotate_hit,
		strafe_right_hit, strafe_left_hit, fast_fall_hit, left_pos_x, right_pos_x,
		input ready);
	modport sink(input valid, left_present, right_present, rotate_hit,
		strafe_right_hit, strafe_left_hit, fast_fall_hit, left_pos_x, right_pos_x,
		output ready);
endinterface

interface tht_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tht_pkg::CFG_IDX_W-1:0]     index;
	logic [tht_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tht_track.sv =====
// Hand tracking state: candidate selection, frame resolve, absence timers.
// Depends on tht_pkg and the assertion macro header.
`include "two_hand_tracker_gestures_defines.svh"

module tht_track #(
	parameter int COORD_BITS = tht_pkg::COORD_BITS_DEF,
	parameter int TIMER_BITS = tht_pkg::TIMER_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              step,
	input  tht_pkg::action_t                                  action,
	input  logic [tht_pkg::BOX_FIELDS-1:0][COORD_BITS-1:0]    box,
	input  logic                                              last,
	input  logic [tht_pkg::TIMEOUT_W-1:0]                     absence_timeout,
	output logic [tht_pkg::BOX_FIELDS-1:0][COORD_BITS-1:0]    left_box_nxt,
	output logic [tht_pkg::BOX_FIELDS-1:0][COORD_BITS-1:0]    right_box_nxt,
	output tht_pkg::presence_t                                seen_nxt
);
	import tht_pkg::*;

	localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

	typedef logic [BOX_FIELDS-1:0][COORD_BITS-1:0] box_vec_t;
	typedef logic [TIMER_BITS-1:0]                 count_t;

	box_vec_t  left_box_q, right_box_q, best_left_q, best_right_q;
	box_vec_t  left_box_d, right_box_d, best_left_d, best_right_d;
	logic      frame_started_q, frame_started_d;
	presence_t seen_q, seen_d;
	presence_t timer_on_q, timer_on_d;
	count_t    left_count_q, right_count_q, left_count_d, right_count_d;

	function automatic logic [COORD_BITS-1:0] coord_gap(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic count_t count_inc(input count_t c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	always_comb begin
		left_box_d      = left_box_q;
		right_box_d     = right_box_q;
		best_left_d     = best_left_q;
		best_right_d    = best_right_q;
		frame_started_d = frame_started_q;
		seen_d          = seen_q;
		timer_on_d      = timer_on_q;
		left_count_d    = left_count_q;
		right_count_d   = right_count_q;
		unique case (action)
			ACT_TICK: begin
				if (timer_on_q.left) begin
					left_count_d = count_inc(left_count_q);
					if (CMP_W'(left_count_d) >= CMP_W'(absence_timeout)) begin
						seen_d.left     = 1'b0;
						timer_on_d.left = 1'b0;
					end
				end
				if (timer_on_q.right) begin
					right_count_d = count_inc(right_count_q);
					if (CMP_W'(right_count_d) >= CMP_W'(absence_timeout)) begin
						seen_d.right     = 1'b0;
						timer_on_d.right = 1'b0;
					end
				end
			end
			ACT_BOX: begin
				if (!frame_started_q) begin
					best_left_d  = box;
					best_right_d = box;
				end else begin
					if (coord_gap(box[BOX_X], left_box_q[BOX_X])
						< coord_gap(best_left_q[BOX_X], left_box_q[BOX_X])) begin
						best_left_d = box;
					end
					if (coord_gap(box[BOX_X], right_box_q[BOX_X])
						< coord_gap(best_right_q[BOX_X], right_box_q[BOX_X])) begin
						best_right_d = box;
					end
				end
				frame_started_d = !last;
				if (last) begin
					if (best_left_d == best_right_d) begin
						// One box for both hands: left takes it only if strictly nearer, else right (ties go right).
						if (coord_gap(best_left_d[BOX_X], left_box_q[BOX_X])
							< coord_gap(best_right_d[BOX_X], right_box_q[BOX_X])) begin
							left_box_d      = best_left_d;
							timer_on_d.left = 1'b0;
							seen_d.left     = 1'b1;
							if (!timer_on_q.right && seen_q.right) begin
								timer_on_d.right = 1'b1;
								right_count_d    = '0;
							end
						end else begin
							right_box_d      = best_right_d;
							timer_on_d.right = 1'b0;
							seen_d.right     = 1'b1;
							if (!timer_on_q.left && seen_q.left) begin
								timer_on_d.left = 1'b1;
								left_count_d    = '0;
							end
						end
					end else begin
						left_box_d  = best_left_d;
						right_box_d = best_right_d;
						seen_d      = '{left: 1'b1, right: 1'b1};
						timer_on_d  = '0;
					end
				end
			end
			ACT_EMPTY: begin
				frame_started_d = 1'b0;
				if (!timer_on_q.left && seen_q.left) begin
					timer_on_d.left = 1'b1;
					left_count_d    = '0;
				end
				if (!timer_on_q.right && seen_q.right) begin
					timer_on_d.right = 1'b1;
					right_count_d    = '0;
				end
			end
			ACT_RSVD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_box_q      <= '0;
			right_box_q     <= '0;
			best_left_q     <= '0;
			best_right_q    <= '0;
			frame_started_q <= 1'b0;
			seen_q          <= '0;
			timer_on_q      <= '0;
			left_count_q    <= '0;
			right_count_q   <= '0;
		end else if (step) begin
			left_box_q      <= left_box_d;
			right_box_q     <= right_box_d;
			best_left_q     <= best_left_d;
			best_right_q    <= best_right_d;
			frame_started_q <= frame_started_d;
			seen_q          <= seen_d;
			timer_on_q      <= timer_on_d;
			left_count_q    <= left_count_d;
			right_count_q   <= right_count_d;
		end
	end

	assign left_box_nxt  = left_box_d;
	assign right_box_nxt = right_box_d;
	assign seen_nxt      = seen_d;

	`THT_ASSERT_IMP(a_left_timer_needs_seen, timer_on_q.left, seen_q.left, "left timer runs for absent hand")
	`THT_ASSERT_IMP(a_right_timer_needs_seen, timer_on_q.right, seen_q.right, "right timer runs for absent hand")
	`THT_ASSERT_NXT(a_frame_closes, step && (action == ACT_BOX) && last, !frame_started_q, "frame still open after last box")

endmodule

// ===== hw/rtl/tht_gesture.sv =====
// Gesture evaluation on the tracked hand boxes after a frame update.
// Depends on tht_pkg.
module tht_gesture #(
	parameter int COORD_BITS = tht_pkg::COORD_BITS_DEF
) (
	input  logic [tht_pkg::BOX_FIELDS-1:0][COORD_BITS-1:0] left_box,
	input  logic [tht_pkg::BOX_FIELDS-1:0][COORD_BITS-1:0] right_box,
	input  tht_pkg::presence_t                             seen,
	input  logic [tht_pkg::FALL_W-1:0]                     fall_threshold,
	output logic                                           rotate_hit,
	output logic                                           strafe_right_hit,
	output logic                                           strafe_left_hit,
	output logic                                           fast_fall_hit
);
	import tht_pkg::*;

	localparam int RW = COORD_BITS + 1;
	localparam int FW = (COORD_BITS > FALL_W) ? COORD_BITS : FALL_W;

	logic                  both;
	logic [RW-1:0]         reach, right_x, reach_gap;
	logic [COORD_BITS-1:0] y_gap;
	logic                  tall_gap, left_higher;

	always_comb begin
		both      = seen.left && seen.right;
		reach     = RW'(left_box[BOX_X]) + RW'(left_box[BOX_W]);
		right_x   = RW'(right_box[BOX_X]);
		reach_gap = (reach > right_x) ? reach - right_x : right_x - reach;
		y_gap     = (left_box[BOX_Y] > right_box[BOX_Y])
			? left_box[BOX_Y] - right_box[BOX_Y] : right_box[BOX_Y] - left_box[BOX_Y];
		tall_gap    = y_gap > (left_box[BOX_H] >> 1);
		left_higher = left_box[BOX_Y] < right_box[BOX_Y];

		rotate_hit       = both && (reach_gap < RW'(left_box[BOX_W] >> 1));
		strafe_right_hit = both && tall_gap && left_higher;
		strafe_left_hit  = both && tall_gap && !left_higher;
		fast_fall_hit    = both && (FW'(left_box[BOX_Y]) > FW'(fall_threshold))
			&& (FW'(right_box[BOX_Y]) > FW'(fall_threshold));
	end

endmodule

// ===== hw/rtl/two_hand_tracker_gestures.sv =====
// Two-hand tracker with gesture detection, top level.
// Depends on tht_pkg, tht_ifs, tht_track, tht_gesture and the macro header.
//
// Usage:
//  - det carries one beat per tick, detected box or empty-frame marker.
//    A box beat with last_in_frame set, or an empty-frame beat, closes a
//    frame and yields exactly one result beat on res; other beats yield none.
//  - cfg writes absence_timeout (index 0) and fall_threshold (index 1);
//    it is always ready and must only be used while the block is idle.
//  - Throughput: one det beat per cycle, sustained, while res keeps up.
//  - Path: a frame-closing beat goes from det into the input stage, then
//    through the track update into the snapshot stage, then through the
//    gesture logic into the result register, which drives res.
//  - Tracking state updates as the beat leaves the input stage, so every
//    beat sees the state left by the one before it.
//  - Stall: when res holds a result with res.ready low and the snapshot
//    stage is full, a frame-closing beat waits in the input stage and
//    det.ready drops, so no beat of any kind enters behind it meanwhile.
//  - Reset clears the tracked boxes, presence, timers and all valid flags;
//    absence_timeout returns to 500 and fall_threshold to 0.
`include "two_hand_tracker_gestures_defines.svh"

module two_hand_tracker_gestures #(
	parameter int COORD_BITS = tht_pkg::COORD_BITS_DEF,
	parameter int TIMER_BITS = tht_pkg::TIMER_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tht_det_if.sink    det,
	tht_cfg_if.sink    cfg,
	tht_out_if.source  res
);
	import tht_pkg::*;

	typedef logic [BOX_FIELDS-1:0][COORD_BITS-1:0] box_vec_t;

	// Configuration registers
	logic [TIMEOUT_W-1:0] absence_timeout_q;
	logic [FALL_W-1:0]    fall_threshold_q;

	// Input stage
	logic     valid_s1;
	action_t  action_s1;
	box_vec_t box_s1;
	logic     last_s1;

	// Snapshot stage: tracked state after a frame-closing beat
	logic      valid_s2;
	box_vec_t  left_box_s2, right_box_s2;
	presence_t seen_s2;

	// Result register
	logic                  out_valid_q;
	presence_t             seen_q;
	logic                  rotate_q, strafe_right_q, strafe_left_q, fast_fall_q;
	logic [COORD_BITS-1:0] left_x_q, right_x_q;

	// Handshake and pipeline control
	logic det_acc, s1_res, s1_adv, s2_load, s2_free, out_load;

	// Track and gesture outputs
	box_vec_t  left_box_nxt, right_box_nxt;
	presence_t seen_nxt;
	logic      rotate_c, strafe_right_c, strafe_left_c, fast_fall_c;

	// Configuration writes: always take the beat.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absence_timeout_q <= ABSENCE_TIMEOUT_RST;
			fall_threshold_q  <= FALL_THRESHOLD_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_ABSENCE_TIMEOUT: absence_timeout_q <= cfg.data[TIMEOUT_W-1:0];
				CFG_FALL_THRESHOLD:  fall_threshold_q  <= cfg.data[FALL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A beat in the input stage needs the snapshot stage only if it closes
	// a frame; everything else advances unconditionally.
	assign s1_res   = valid_s1 && (((action_s1 == ACT_BOX) && last_s1)
		|| (action_s1 == ACT_EMPTY));
	assign out_load = valid_s2 && (!out_valid_q || res.ready);
	assign s2_free  = !valid_s2 || out_load;
	assign s1_adv   = valid_s1 && (!s1_res || s2_free);
	assign s2_load  = s1_adv && s1_res;
	assign det.ready = !valid_s1 || s1_adv;
	assign det_acc  = det.valid && det.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (det_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
			end else if (out_load) begin
				valid_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold unless a new beat loads them.
	always_ff @(posedge clk) begin
		if (det_acc) begin
			action_s1         <= action_t'(det.action);
			box_s1[BOX_X]     <= det.box_x;
			box_s1[BOX_Y]     <= det.box_y;
			box_s1[BOX_W]     <= det.box_width;
			box_s1[BOX_H]     <= det.box_height;
			last_s1           <= det.last_in_frame;
		end
		if (s2_load) begin
			left_box_s2  <= left_box_nxt;
			right_box_s2 <= right_box_nxt;
			seen_s2      <= seen_nxt;
		end
		if (out_load) begin
			seen_q         <= seen_s2;
			rotate_q       <= rotate_c;
			strafe_right_q <= strafe_right_c;
			strafe_left_q  <= strafe_left_c;
			fast_fall_q    <= fast_fall_c;
			left_x_q       <= left_box_s2[BOX_X];
			right_x_q      <= right_box_s2[BOX_X];
		end
	end

	tht_track #(
		.COORD_BITS(COORD_BITS),
		.TIMER_BITS(TIMER_BITS)
	) u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (s1_adv),
		.action          (action_s1),
		.box             (box_s1),
		.last            (last_s1),
		.absence_timeout (absence_timeout_q),
		.left_box_nxt    (left_box_nxt),
		.right_box_nxt   (right_box_nxt),
		.seen_nxt        (seen_nxt)
	);

	tht_gesture #(
		.COORD_BITS(COORD_BITS)
	) u_gesture (
		.left_box         (left_box_s2),
		.right_box        (right_box_s2),
		.seen             (seen_s2),
		.fall_threshold   (fall_threshold_q),
		.rotate_hit       (rotate_c),
		.strafe_right_hit (strafe_right_c),
		.strafe_left_hit  (strafe_left_c),
		.fast_fall_hit    (fast_fall_c)
	);

	assign res.valid            = out_valid_q;
	assign res.left_present     = seen_q.left;
	assign res.right_present    = seen_q.right;
	assign res.rotate_hit       = rotate_q;
	assign res.strafe_right_hit = strafe_right_q;
	assign res.strafe_left_hit  = strafe_left_q;
	assign res.fast_fall_hit    = fast_fall_q;
	assign res.left_pos_x       = left_x_q;
	assign res.right_pos_x      = right_x_q;

	`THT_ASSERT_NXT(a_det_lands, det_acc, valid_s1, "accepted beat missing from input stage")
	`THT_ASSERT_IMP(a_close_waits, s1_res && !s2_free, !s1_adv, "frame close overran a full snapshot stage")
	`THT_ASSERT_NXT(a_result_loads, out_load, out_valid_q, "snapshot moved without a result")

endmodule
